@@ sv/spm_pkg.sv @@
// Shared constants, codes and types for the servo position mapper.
// No dependencies; imported by servo_position_mapper_unit.
package spm_pkg;

  // Channel count and table index width
  localparam int CHANNELS = 16;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Command codes
  localparam logic [2:0] CMD_SET_PULSE = 3'd0;
  localparam logic [2:0] CMD_SET_ANGLE = 3'd1;
  localparam logic [2:0] CMD_OFF       = 3'd2;
  localparam logic [2:0] CMD_ALL_OFF   = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [1:0] REG_MIN_ANGLE = 2'd2;
  localparam logic [1:0] REG_MAX_ANGLE = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_MIN_PULSE = 16'd500;
  localparam logic [15:0] RST_MAX_PULSE = 16'd2500;
  localparam logic [16:0] RST_MIN_ANGLE = 17'd0;
  localparam logic [16:0] RST_MAX_ANGLE = 17'd18000;

  // Pulse limits and duty conversion (50 Hz frame, 12-bit duty)
  localparam logic [11:0] PULSE_FLOOR = 12'd100;
  localparam logic [11:0] PULSE_CEIL  = 12'd3000;
  localparam logic [11:0] DUTY_MAX    = 12'd4095;
  localparam logic [16:0] FRAME_US    = 17'd20000;
  localparam logic [23:0] FRAME_HALF  = 24'd10000;
  localparam int          DUTY_SHIFT  = 12;

  // Duty by reciprocal: (pulse * 4096 + 10000) / 20000 equals
  // ((pulse << 7) + 312) / 625, exact as (x * ceil(2^28 / 625)) >> 28
  // for any 12-bit pulse
  localparam logic [19:0] DUTY_BIAS   = 20'd312;
  localparam logic [19:0] DUTY_RECIP  = 20'd429497;
  localparam int          DUTY_RSHIFT = 28;

  // Divider: two quotient bits per cycle
  localparam int          DQ_W        = 36;
  localparam int          CNT_W       = 5;
  localparam logic [4:0]  STEPS_ANGLE = 5'd18;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RANGE,
    S_MUL,
    S_DIV_LOAD,
    S_ANG_DIV,
    S_ADD,
    S_CLAMP,
    S_DUTY_LOAD,
    S_DUTY_END,
    S_FINISH
  } state_t;

endpackage

@@ sv/servo_position_mapper_unit.sv @@
// Servo position mapper: command decode, pulse table, angle interpolation over
// one restoring divider and duty conversion by reciprocal multiply.
// Depends on spm_pkg.
//
// A request is taken when start is high and busy is low; busy stays high until
// the result has been shown. The done signal is high for a single cycle, in
// which the result is valid on the outputs; the receiver cannot stall it.
// From decode, channel off, all off and rejected requests go to finish;
// a read (or unknown code) passes through duty load, and also through duty
// end when the channel is driven, as set pulse does. Set angle passes range,
// multiply, divider load, the interpolation divide, add and clamp before duty
// load and duty end. The divider retires two quotient bits per cycle and sets
// the length of a set-angle request. Configuration writes are taken at any
// edge with wr_en high.
module servo_position_mapper_unit
  import spm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [16:0]        wr_data,
  input  logic [2:0]         command,
  input  logic [7:0]         channel,
  input  logic [15:0]        pulse_request_us,
  input  logic signed [16:0] angle_request,
  output logic [3:0]         out_channel,
  output logic [11:0]        pulse_us,
  output logic [11:0]        duty_count,
  output logic               rejected
);

  state_t state, state_next;

  // Configuration
  logic [15:0]        min_pulse_us;
  logic [15:0]        max_pulse_us;
  logic signed [16:0] min_angle;
  logic signed [16:0] max_angle;

  // Latched request
  logic [2:0]         cmd_r;
  logic [7:0]         ch_r;
  logic [15:0]        req_r;
  logic signed [16:0] ang_r;

  // Pulse table
  logic [11:0] pulse_table [CHANNELS];

  // Interpolation datapath
  logic signed [17:0] diff;
  logic [16:0]        span;
  logic signed [34:0] num;
  logic               neg;
  logic [36:0]        psum;

  // Divider
  logic [16:0]      rem;
  logic [DQ_W-1:0]  dq;
  logic [16:0]      divisor;
  logic [CNT_W-1:0] cnt;

  // Duty conversion
  logic [39:0]      duty_prod;

  // Combinational helpers
  logic               ch_ok;
  logic [CH_W-1:0]    idx;
  logic [11:0]        req_clamped;
  logic signed [16:0] ang_lo;
  logic signed [16:0] ang_cl;
  logic signed [17:0] diff_c;
  logic signed [17:0] span_c;
  logic signed [16:0] pd;
  logic [34:0]        mag;
  logic [36:0]        q_signed;
  logic [19:0]        duty_num;
  logic [17:0]        r1s, r2s;
  logic               b1, b2;
  logic [16:0]        r1, r2;
  logic [DQ_W-1:0]    dq1, dq2;

  // Decode and range helpers
  always_comb begin
    ch_ok = (ch_r < 8'(CHANNELS));
    idx   = ch_r[CH_W-1:0];
    if (req_r < 16'(PULSE_FLOOR)) begin
      req_clamped = PULSE_FLOOR;
    end else if (req_r > 16'(PULSE_CEIL)) begin
      req_clamped = PULSE_CEIL;
    end else begin
      req_clamped = req_r[11:0];
    end
    ang_lo = (ang_r < min_angle) ? min_angle : ang_r;
    ang_cl = (ang_lo > max_angle) ? max_angle : ang_lo;
    diff_c = {ang_cl[16], ang_cl} - {min_angle[16], min_angle};
    span_c = {max_angle[16], max_angle} - {min_angle[16], min_angle};
    pd     = $signed({1'b0, max_pulse_us}) - $signed({1'b0, min_pulse_us});
    mag    = num[34] ? 35'(-num) : 35'(num);
    q_signed = neg ? (37'd0 - {1'b0, dq}) : {1'b0, dq};
    duty_num = {1'b0, pulse_us, 7'd0} + DUTY_BIAS;
  end

  // Divider: two restoring steps per cycle
  always_comb begin
    r1s = {rem, dq[DQ_W-1]};
    b1  = (r1s >= {1'b0, divisor});
    r1  = b1 ? 17'(r1s - {1'b0, divisor}) : r1s[16:0];
    dq1 = {dq[DQ_W-2:0], b1};
    r2s = {r1, dq1[DQ_W-1]};
    b2  = (r2s >= {1'b0, divisor});
    r2  = b2 ? 17'(r2s - {1'b0, divisor}) : r2s[16:0];
    dq2 = {dq1[DQ_W-2:0], b2};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (cmd_r == CMD_ALL_OFF || !ch_ok || cmd_r == CMD_OFF) begin
          state_next = S_FINISH;
        end else if (cmd_r == CMD_SET_ANGLE) begin
          state_next = S_RANGE;
        end else begin
          state_next = S_DUTY_LOAD;
        end
      end
      S_RANGE:     state_next = S_MUL;
      S_MUL:       state_next = S_DIV_LOAD;
      S_DIV_LOAD:  state_next = S_ANG_DIV;
      S_ANG_DIV: begin
        if (cnt == CNT_W'(1)) state_next = S_ADD;
      end
      S_ADD:       state_next = S_CLAMP;
      S_CLAMP:     state_next = S_DUTY_LOAD;
      S_DUTY_LOAD: begin
        state_next = (pulse_us == 12'd0) ? S_FINISH : S_DUTY_END;
      end
      S_DUTY_END:  state_next = S_FINISH;
      S_FINISH:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_FINISH);
  end

  // Sequencer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      min_pulse_us <= RST_MIN_PULSE;
      max_pulse_us <= RST_MAX_PULSE;
      min_angle    <= RST_MIN_ANGLE;
      max_angle    <= RST_MAX_ANGLE;
    end else begin
      state <= state_next;
      if (wr_en) begin
        case (wr_index)
          REG_MIN_PULSE: min_pulse_us <= wr_data[15:0];
          REG_MAX_PULSE: max_pulse_us <= wr_data[15:0];
          REG_MIN_ANGLE: min_angle    <= wr_data;
          REG_MAX_ANGLE: max_angle    <= wr_data;
          default: ;
        endcase
      end
    end
  end

  // Pulse table: clear on reset and all off, write on set and off
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) pulse_table[i] <= 12'd0;
    end else begin
      case (state)
        S_DECODE: begin
          if (cmd_r == CMD_ALL_OFF) begin
            for (int i = 0; i < CHANNELS; i++) pulse_table[i] <= 12'd0;
          end else if (ch_ok) begin
            if (cmd_r == CMD_SET_PULSE) pulse_table[idx] <= req_clamped;
            else if (cmd_r == CMD_OFF) pulse_table[idx] <= 12'd0;
          end
        end
        S_CLAMP: begin
          if (psum[36]) begin
            pulse_table[idx] <= PULSE_FLOOR;
          end else if (psum > 37'(PULSE_CEIL)) begin
            pulse_table[idx] <= PULSE_CEIL;
          end else if (psum < 37'(PULSE_FLOOR)) begin
            pulse_table[idx] <= PULSE_FLOOR;
          end else begin
            pulse_table[idx] <= psum[11:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: latch request, interpolate, divide, convert
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r <= command;
        ch_r  <= channel;
        req_r <= pulse_request_us;
        ang_r <= angle_request;
      end
      S_DECODE: begin
        out_channel <= ch_r[3:0];
        duty_count  <= 12'd0;
        if (cmd_r == CMD_ALL_OFF) begin
          rejected <= 1'b0;
          pulse_us <= 12'd0;
        end else if (!ch_ok) begin
          rejected <= 1'b1;
          pulse_us <= 12'd0;
        end else begin
          rejected <= 1'b0;
          case (cmd_r)
            CMD_SET_PULSE: pulse_us <= req_clamped;
            CMD_OFF:       pulse_us <= 12'd0;
            default:       pulse_us <= pulse_table[idx];
          endcase
        end
      end
      S_RANGE: begin
        diff <= diff_c;
        span <= (span_c < 18'sd1) ? 17'd1 : span_c[16:0];
      end
      S_MUL: begin
        num <= 35'(diff * pd);
      end
      S_DIV_LOAD: begin
        neg     <= num[34];
        rem     <= 17'd0;
        dq      <= {1'b0, mag};
        divisor <= span;
        cnt     <= STEPS_ANGLE;
      end
      S_ANG_DIV: begin
        rem <= r2;
        dq  <= dq2;
        cnt <= cnt - CNT_W'(1);
      end
      S_ADD: begin
        psum <= {21'd0, min_pulse_us} + q_signed;
      end
      S_CLAMP: begin
        if (psum[36]) begin
          pulse_us <= PULSE_FLOOR;
        end else if (psum > 37'(PULSE_CEIL)) begin
          pulse_us <= PULSE_CEIL;
        end else if (psum < 37'(PULSE_FLOOR)) begin
          pulse_us <= PULSE_FLOOR;
        end else begin
          pulse_us <= psum[11:0];
        end
      end
      // Scale the pulse by the reciprocal of the frame length
      S_DUTY_LOAD: begin
        duty_prod <= 40'(duty_num) * 40'(DUTY_RECIP);
      end
      // The quotient stays below DUTY_MAX for any 12-bit pulse
      S_DUTY_END: begin
        duty_count <= duty_prod[DUTY_RSHIFT +: 12];
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // Return to idle right after the result cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block still busy after result");

  // A taken request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Rejected requests report nothing stored
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |-> (pulse_us == 12'd0 && duty_count == 12'd0))
    else $error("rejected result carries a pulse");

  // An off channel has zero duty, an on channel a nonzero one in range
  a_off_duty: assert property (@(posedge clk) disable iff (rst)
    (done && pulse_us == 12'd0) |-> (duty_count == 12'd0))
    else $error("duty nonzero for an off channel");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    (done && pulse_us != 12'd0) |->
      (pulse_us >= PULSE_FLOOR && pulse_us <= PULSE_CEIL && duty_count != 12'd0))
    else $error("stored pulse out of range");
`endif

endmodule
